// ===== rtl/vbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and constants of the version blink sequencer.
// ----------------------------------------------------------------------------
package vbs_pkg;

    // Field and register widths
    localparam int unsigned VERSION_W = 16;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned UPPER_W   = 10;
    localparam int unsigned LOWER_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE    = 2'd2;

    // Register reset values
    localparam logic [TICKS_W-1:0] LONG_OFF_RST = 16'd2000;
    localparam logic [TICKS_W-1:0] PAUSE_RST    = 16'd1000;
    localparam logic [TICKS_W-1:0] PHASE_RST    = 16'd500;

    // Digit grouping
    localparam int unsigned DIGIT_BASE = 10;
    localparam int unsigned SPLIT_BASE = 100;

    // Divide by 100 as multiply by reciprocal: floor(v * 83887 / 2^23) is exact
    // for every 16-bit v.
    localparam int unsigned DIV_MUL_W = 17;
    localparam int unsigned DIV_SHIFT = 23;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd83887;
    localparam int unsigned DIV_PROD_W = VERSION_W + DIV_MUL_W;

    // Duration registers
    typedef struct packed {
        logic [TICKS_W-1:0] long_off_ticks;
        logic [TICKS_W-1:0] pause_ticks;
        logic [TICKS_W-1:0] phase_ticks;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic led_upper;
        logic led_lower;
        logic showing;
    } t_result;

endpackage

// ===== rtl/version_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// version_blink_sequencer
// Blinks a version number as digit groups on two status LEDs.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes through the input register, then the
//   state update into the result register.
// Throughput: one beat per cycle; a stalled result holds the result register,
//   and the input register takes one more beat before the input side stalls.
// Reset: synchronous, active low; clears the sequence state and pipeline
//   valids and loads the duration registers with 2000, 1000 and 500 ticks.
module version_blink_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vbs_pkg::TICKS_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [vbs_pkg::VERSION_W-1:0] i_version,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_led_upper,
    output logic                          o_led_lower,
    output logic                          o_showing
);

    vbs_pkg::t_cfg                 r_cfg;
    logic                          r_in_valid;
    logic                          r_req_type;
    logic [vbs_pkg::VERSION_W-1:0] r_version;
    logic [vbs_pkg::UPPER_W-1:0]   r_quot;
    logic                          r_out_valid;
    vbs_pkg::t_result              r_result;

    logic [vbs_pkg::UPPER_W-1:0]   w_quot;
    vbs_pkg::t_result              w_result;
    logic                          w_advance;
    logic                          w_in_take;
    logic                          w_exec;

    // Duration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_off_ticks <= vbs_pkg::LONG_OFF_RST;
            r_cfg.pause_ticks    <= vbs_pkg::PAUSE_RST;
            r_cfg.phase_ticks    <= vbs_pkg::PHASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vbs_pkg::REG_LONG_OFF: r_cfg.long_off_ticks <= i_cfg_data;
                vbs_pkg::REG_PAUSE:    r_cfg.pause_ticks    <= i_cfg_data;
                vbs_pkg::REG_PHASE:    r_cfg.phase_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: advance when the result register is free or being drained
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_exec     = r_in_valid && w_advance;

    // Split off the upper part ahead of the input register
    vbs_div100 u_div100 (
        .i_version (i_version),
        .o_quot    (w_quot)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req_type <= i_req_type;
            r_version  <= i_version;
            r_quot     <= w_quot;
        end
    end

    vbs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_exec),
        .i_req_type (r_req_type),
        .i_version  (r_version),
        .i_quot     (r_quot),
        .i_cfg      (r_cfg),
        .o_result   (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_upper = r_result.led_upper;
    assign o_led_lower = r_result.led_lower;
    assign o_showing   = r_result.showing;

    // Dark LEDs whenever the sequence is not showing
    a_dark_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_showing |-> !o_led_upper && !o_led_lower)
        else $error("LED lit while the sequence is not showing");

    // Stall only with a held beat in the input register
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // A beat that leaves the input register shows up as a result
    a_exec_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_out_valid)
        else $error("executed beat produced no result");

endmodule

// ===== rtl/vbs_div100.sv =====
// ----------------------------------------------------------------------------
// vbs_div100
// Quotient of the version by 100, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module vbs_div100 (
    input  logic [vbs_pkg::VERSION_W-1:0] i_version,
    output logic [vbs_pkg::UPPER_W-1:0]   o_quot
);

    logic [vbs_pkg::DIV_PROD_W-1:0] w_prod;

    // Scale by the reciprocal and keep the integer part
    assign w_prod = vbs_pkg::DIV_PROD_W'(i_version) * vbs_pkg::DIV_PROD_W'(vbs_pkg::DIV_MUL);
    assign o_quot = w_prod[vbs_pkg::DIV_SHIFT +: vbs_pkg::UPPER_W];

endmodule

// ===== rtl/vbs_core.sv =====
// ----------------------------------------------------------------------------
// vbs_core
// Blink state machine: start/stop handling, tick timer and LED drive.
// ----------------------------------------------------------------------------
module vbs_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_req_type,
    input  logic [vbs_pkg::VERSION_W-1:0] i_version,
    input  logic [vbs_pkg::UPPER_W-1:0]   i_quot,
    input  vbs_pkg::t_cfg                 i_cfg,
    output vbs_pkg::t_result              o_result
);

    typedef enum logic [3:0] {
        ST_BEGIN   = 4'd0,
        ST_UP_TEN  = 4'd1,
        ST_UP_ONE  = 4'd2,
        ST_UP_OFF  = 4'd3,
        ST_LO_TEN  = 4'd4,
        ST_LO_ONE  = 4'd5,
        ST_LO_OFF  = 4'd6,
        ST_END     = 4'd7,
        ST_PAUSE_A = 4'd8,
        ST_PAUSE_B = 4'd9,
        ST_PAUSE_C = 4'd10
    } t_phase;

    localparam int unsigned PROD_W = vbs_pkg::VERSION_W + 1;

    t_phase                        r_state, n_state;
    logic                          r_running, n_running;
    logic [vbs_pkg::TICKS_W-1:0]   r_elapsed, n_elapsed;
    logic [vbs_pkg::UPPER_W-1:0]   r_upper_left, n_upper_left;
    logic [vbs_pkg::LOWER_W-1:0]   r_lower_left, n_lower_left;
    logic                          r_upper_led, n_upper_led;
    logic                          r_lower_led, n_lower_led;

    logic [PROD_W-1:0]             w_quot_x100;
    logic [vbs_pkg::VERSION_W-1:0] w_rem;
    logic [vbs_pkg::TICKS_W-1:0]   w_dur;
    logic [vbs_pkg::TICKS_W:0]     w_next_cnt;
    logic                          w_fire;
    logic                          w_upper_tens;
    logic                          w_upper_any;
    logic                          w_lower_tens;
    logic                          w_lower_any;

    // Remainder of the version by 100
    assign w_quot_x100 = PROD_W'(i_quot) * PROD_W'(vbs_pkg::SPLIT_BASE);
    assign w_rem       = i_version - w_quot_x100[vbs_pkg::VERSION_W-1:0];

    // Pick the duration of the current state
    always_comb begin
        case (r_state)
            ST_PAUSE_A, ST_PAUSE_B, ST_PAUSE_C: w_dur = i_cfg.pause_ticks;
            ST_UP_TEN, ST_UP_ONE, ST_UP_OFF,
            ST_LO_TEN, ST_LO_ONE, ST_LO_OFF:     w_dur = i_cfg.phase_ticks;
            default:                             w_dur = i_cfg.long_off_ticks;
        endcase
    end

    // Timer fires once the count reaches the duration
    assign w_next_cnt = {1'b0, r_elapsed} + (vbs_pkg::TICKS_W+1)'(1);
    assign w_fire     = w_next_cnt >= {1'b0, w_dur};

    assign w_upper_tens = r_upper_left >= vbs_pkg::UPPER_W'(vbs_pkg::DIGIT_BASE);
    assign w_upper_any  = r_upper_left != '0;
    assign w_lower_tens = r_lower_left >= vbs_pkg::LOWER_W'(vbs_pkg::DIGIT_BASE);
    assign w_lower_any  = r_lower_left != '0;

    // Next state for one beat
    always_comb begin
        n_state      = r_state;
        n_running    = r_running;
        n_elapsed    = r_elapsed;
        n_upper_left = r_upper_left;
        n_lower_left = r_lower_left;
        n_upper_led  = r_upper_led;
        n_lower_led  = r_lower_led;

        if (i_req_type) begin
            if (r_running) begin
                // Stop: keep everything else
                n_running = 1'b0;
            end else begin
                // Start: load both parts and restart the timer
                n_running    = 1'b1;
                n_state      = ST_BEGIN;
                n_elapsed    = '0;
                n_upper_left = i_quot;
                n_lower_left = w_rem[vbs_pkg::LOWER_W-1:0];
            end
        end else if (r_running) begin
            n_elapsed = w_fire ? '0 : w_next_cnt[vbs_pkg::TICKS_W-1:0];
            case (r_state)
                ST_BEGIN, ST_PAUSE_A: begin
                    if (w_fire) begin
                        n_state = ST_UP_OFF;
                    end
                    n_upper_led = 1'b0;
                    n_lower_led = 1'b0;
                end
                ST_PAUSE_B, ST_PAUSE_C: begin
                    if (w_fire) begin
                        n_state = ST_LO_OFF;
                    end
                    n_upper_led = 1'b0;
                    n_lower_led = 1'b0;
                end
                ST_UP_OFF: begin
                    if (w_fire) begin
                        if (w_upper_tens) begin
                            n_upper_left = r_upper_left
                                           - vbs_pkg::UPPER_W'(vbs_pkg::DIGIT_BASE);
                            n_state      = ST_UP_TEN;
                            n_lower_led  = 1'b1;
                        end else if (w_upper_any) begin
                            n_upper_left = r_upper_left - vbs_pkg::UPPER_W'(1);
                            n_state      = ST_UP_ONE;
                            n_lower_led  = 1'b0;
                        end else begin
                            n_state = ST_PAUSE_B;
                        end
                    end
                    n_upper_led = 1'b0;
                end
                ST_UP_ONE: begin
                    if (w_fire) begin
                        n_state = ST_UP_OFF;
                    end
                    n_lower_led = 1'b0;
                    n_upper_led = 1'b1;
                end
                ST_UP_TEN: begin
                    if (w_fire) begin
                        if (w_upper_tens) begin
                            n_state = ST_UP_OFF;
                        end else if (w_upper_any) begin
                            n_state = ST_PAUSE_A;
                        end else begin
                            n_state = ST_PAUSE_B;
                        end
                    end
                    n_lower_led = 1'b1;
                    n_upper_led = 1'b1;
                end
                ST_LO_OFF: begin
                    if (w_fire) begin
                        if (w_lower_tens) begin
                            n_lower_left = r_lower_left
                                           - vbs_pkg::LOWER_W'(vbs_pkg::DIGIT_BASE);
                            n_state      = ST_LO_TEN;
                            n_upper_led  = 1'b1;
                        end else if (w_lower_any) begin
                            n_lower_left = r_lower_left - vbs_pkg::LOWER_W'(1);
                            n_state      = ST_LO_ONE;
                            n_upper_led  = 1'b0;
                        end else begin
                            n_state = ST_END;
                        end
                    end
                    n_lower_led = 1'b0;
                end
                ST_LO_ONE: begin
                    if (w_fire) begin
                        n_state = ST_LO_OFF;
                    end
                    n_upper_led = 1'b0;
                    n_lower_led = 1'b1;
                end
                ST_LO_TEN: begin
                    if (w_fire) begin
                        if (w_lower_tens) begin
                            n_state = ST_LO_OFF;
                        end else if (w_lower_any) begin
                            n_state = ST_PAUSE_C;
                        end else begin
                            n_state = ST_END;
                        end
                    end
                    n_upper_led = 1'b1;
                    n_lower_led = 1'b1;
                end
                default: begin
                    // Final dark period ends the sequence
                    if (w_fire) begin
                        n_state   = ST_END;
                        n_running = 1'b0;
                    end
                    n_upper_led = 1'b0;
                    n_lower_led = 1'b0;
                end
            endcase
        end
    end

    // Hold state, advance on each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_BEGIN;
            r_running    <= 1'b0;
            r_elapsed    <= '0;
            r_upper_left <= '0;
            r_lower_left <= '0;
            r_upper_led  <= 1'b0;
            r_lower_led  <= 1'b0;
        end else if (i_en) begin
            r_state      <= n_state;
            r_running    <= n_running;
            r_elapsed    <= n_elapsed;
            r_upper_left <= n_upper_left;
            r_lower_left <= n_lower_left;
            r_upper_led  <= n_upper_led;
            r_lower_led  <= n_lower_led;
        end
    end

    // Result of this beat, from the updated state
    assign o_result.led_upper = n_running & n_upper_led;
    assign o_result.led_lower = n_running & n_lower_led;
    assign o_result.showing   = n_running;

endmodule
